// ===== src/tss_pkg.sv =====
// Package for the triangle scanline span block: payload structs, pipeline
// stage structs and the restoring divider step. Depends on nothing.
package tss_pkg;

   localparam int COORD_BITS = 12;
   localparam int PROD_BITS  = 2 * COORD_BITS;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic        [COORD_BITS-1:0] mag_type;
   typedef logic        [PROD_BITS-1:0]  prod_type;

   typedef struct packed {
      coord_type   vert_a_x;
      coord_type   vert_a_y;
      coord_type   vert_b_x;
      coord_type   vert_b_y;
      coord_type   vert_c_x;
      coord_type   vert_c_y;
      coord_type   scan_row;
      logic [23:0] fill_rgb;
      logic [7:0]  fill_alpha;
   } req_type;

   typedef struct packed {
      logic        span_valid;
      coord_type   span_left;
      coord_type   span_right;
      coord_type   span_row;
      logic [23:0] span_rgb;
      logic [7:0]  span_alpha;
   } rsp_type;

   // Vertices ordered top, middle, bottom by y.
   typedef struct packed {
      coord_type   xt;
      coord_type   yt;
      coord_type   xm;
      coord_type   ym;
      coord_type   xb;
      coord_type   yb;
      coord_type   row;
      logic [23:0] rgb;
      logic [7:0]  alpha;
   } sort_type;

   // Values that pass untouched alongside both edge lanes.
   typedef struct packed {
      logic        span_ok;
      coord_type   row;
      logic [23:0] rgb;
      logic [7:0]  alpha;
   } side_type;

   // One edge before the multiply: x = x0 +/- (dr * adx) / dy.
   typedef struct packed {
      logic      neg;
      coord_type x0;
      mag_type   dr;
      mag_type   adx;
      mag_type   dy;
   } edge_type;

   typedef struct packed {
      side_type side;
      edge_type lng;
      edge_type sht;
   } edge_item_type;

   // One edge inside the divider.
   typedef struct packed {
      logic      neg;
      coord_type x0;
      prod_type  rem;
      mag_type   den;
      mag_type   quo;
   } div_lane_type;

   typedef struct packed {
      side_type     side;
      div_lane_type lng;
      div_lane_type sht;
   } div_item_type;

   // One restoring division step producing quotient bit bit_idx.
   function automatic div_lane_type div_step(div_lane_type lane, int unsigned bit_idx);
      prod_type     dsh;
      div_lane_type res;
      res = lane;
      dsh = {{COORD_BITS{1'b0}}, lane.den} << bit_idx;
      if (lane.rem >= dsh) begin
         res.rem = lane.rem - dsh;
         res.quo = lane.quo | (mag_type'(1) << bit_idx);
      end
      return res;
   endfunction

endpackage

// ===== src/tss_div_pipe.sv =====
// Pipelined restoring divider for both edge lanes, one quotient bit per
// stage with valid bits and a per-stage ready chain. Depends on tss_pkg.
module tss_div_pipe (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  tss_pkg::div_item_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output tss_pkg::div_item_type out_data
);
   import tss_pkg::*;

   localparam int STAGES = COORD_BITS;

   div_item_type data_ff [STAGES];
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] adv;

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      div_item_type prev_data;
      logic         prev_valid;
      div_item_type step_in;

      if (s == 0) begin : g_first
         assign prev_data  = in_data;
         assign prev_valid = in_valid;
      end else begin : g_next
         assign prev_data  = data_ff[s-1];
         assign prev_valid = valid_ff[s-1];
      end

      if (s == STAGES - 1) begin : g_last_adv
         assign adv[s] = !valid_ff[s] || out_ready;
      end else begin : g_mid_adv
         assign adv[s] = !valid_ff[s] || adv[s+1];
      end

      always_comb begin
         step_in     = prev_data;
         step_in.lng = div_step(prev_data.lng, (STAGES - 1 - s));
         step_in.sht = div_step(prev_data.sht, (STAGES - 1 - s));
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (adv[s]) begin
            valid_ff[s] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv[s]) begin
            data_ff[s] <= step_in;
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_data  = data_ff[STAGES-1];

endmodule

// ===== src/triangle_scanline_span_top.sv =====
// Top level of the triangle scanline span generator: sort, edge setup,
// multiply, pipelined divide and span assembly. Depends on tss_pkg, tss_div_pipe.
//
// Usage: each transfer on the req_ channel carries three triangle vertices, a
// scanline row, a fill color and an opacity. Exactly one transfer leaves on the
// rsp_ channel for each one taken, in order, giving the ordered left and right
// x of the span on that row, the row itself, the color and the opacity.
// span_valid is low, with left and right zero, for a flat triangle or a row
// outside the triangle.
// Throughput: one transfer per clock, sustained while rsp_ready keeps up. A
// req_ transfer passes through stages 0 to 3, the pipelined restoring
// divider, which resolves one quotient bit per stage, and the output register.
// Every stage holds a valid bit and advances when it is empty or the stage
// after it advances, so bubbles are squeezed out and the block keeps taking
// transfers while a finished result waits on rsp_ready, until every stage is
// full. A stall loses or repeats nothing.
// Reset (synchronous, active high) empties the pipeline by clearing every valid bit; data registers are not reset.
module triangle_scanline_span_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tss_pkg::rsp_type rsp_data
);
   import tss_pkg::*;

   // Stage 0 registers the raw request, stage 1 the sorted vertices,
   // stage 2 the edge setup and stage 3 the products.
   req_type       s0_ff;
   sort_type      s1_ff, s1_in;
   edge_item_type s2_ff, s2_in;
   div_item_type  s3_ff, s3_in;
   logic          s0_valid_ff, s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic          adv0, adv1, adv2, adv3, adv_out;

   logic          div_in_ready;
   logic          div_out_valid;
   div_item_type  div_out_data;

   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff;

   // The ready chain runs back from the output register.
   assign adv_out   = !rsp_valid_ff || rsp_ready;
   assign adv3      = !s3_valid_ff || div_in_ready;
   assign adv2      = !s2_valid_ff || adv3;
   assign adv1      = !s1_valid_ff || adv2;
   assign adv0      = !s0_valid_ff || adv1;
   assign req_ready = adv0;

   // Stable three-step sort by y, so equal rows keep input order.
   always_comb begin
      coord_type ax, ay, bx, by, cx, cy, tx, ty;
      tx = '0;
      ty = '0;
      ax = s0_ff.vert_a_x;
      ay = s0_ff.vert_a_y;
      bx = s0_ff.vert_b_x;
      by = s0_ff.vert_b_y;
      cx = s0_ff.vert_c_x;
      cy = s0_ff.vert_c_y;
      if (ay > by) begin
         tx = ax; ty = ay; ax = bx; ay = by; bx = tx; by = ty;
      end
      if (by > cy) begin
         tx = bx; ty = by; bx = cx; by = cy; cx = tx; cy = ty;
      end
      if (ay > by) begin
         tx = ax; ty = ay; ax = bx; ay = by; bx = tx; by = ty;
      end
      s1_in.xt    = ax;
      s1_in.yt    = ay;
      s1_in.xm    = bx;
      s1_in.ym    = by;
      s1_in.xb    = cx;
      s1_in.yb    = cy;
      s1_in.row   = s0_ff.scan_row;
      s1_in.rgb   = s0_ff.fill_rgb;
      s1_in.alpha = s0_ff.fill_alpha;
   end

   // Edge setup: differences with sign split off. The slope numerator's sign
   // comes only from dx, since the row offset is never negative for a span
   // that is inside the triangle. Equal-y guards become a zero numerator.
   always_comb begin
      logic signed [COORD_BITS:0] dx_long, dx_short;
      coord_type sx0, sx1, sy0, sy1;
      logic      guard;

      dx_long = {s1_ff.xb[COORD_BITS-1], s1_ff.xb} - {s1_ff.xt[COORD_BITS-1], s1_ff.xt};
      s2_in.lng.neg = dx_long[COORD_BITS];
      s2_in.lng.x0  = s1_ff.xt;
      s2_in.lng.adx = dx_long[COORD_BITS] ? COORD_BITS'(-dx_long) : COORD_BITS'(dx_long);
      s2_in.lng.dy  = COORD_BITS'(s1_ff.yb - s1_ff.yt);
      s2_in.lng.dr  = COORD_BITS'(s1_ff.row - s1_ff.yt);

      if (s1_ff.row < s1_ff.ym) begin
         sx0 = s1_ff.xt; sy0 = s1_ff.yt; sx1 = s1_ff.xm; sy1 = s1_ff.ym;
      end else begin
         sx0 = s1_ff.xm; sy0 = s1_ff.ym; sx1 = s1_ff.xb; sy1 = s1_ff.yb;
      end
      guard    = (sy0 == sy1);
      dx_short = {sx1[COORD_BITS-1], sx1} - {sx0[COORD_BITS-1], sx0};
      s2_in.sht.neg = dx_short[COORD_BITS];
      s2_in.sht.x0  = sx0;
      s2_in.sht.adx = dx_short[COORD_BITS] ? COORD_BITS'(-dx_short) : COORD_BITS'(dx_short);
      s2_in.sht.dy  = guard ? mag_type'(1) : COORD_BITS'(sy1 - sy0);
      s2_in.sht.dr  = guard ? '0 : COORD_BITS'(s1_ff.row - sy0);

      s2_in.side.span_ok = (s1_ff.yt != s1_ff.yb) && (s1_ff.row >= s1_ff.yt)
                           && (s1_ff.row <= s1_ff.yb);
      s2_in.side.row     = s1_ff.row;
      s2_in.side.rgb     = s1_ff.rgb;
      s2_in.side.alpha   = s1_ff.alpha;
   end

   // Unsigned products of row offset and x span magnitude.
   always_comb begin
      s3_in.side    = s2_ff.side;
      s3_in.lng.neg = s2_ff.lng.neg;
      s3_in.lng.x0  = s2_ff.lng.x0;
      s3_in.lng.rem = {{COORD_BITS{1'b0}}, s2_ff.lng.dr} * {{COORD_BITS{1'b0}}, s2_ff.lng.adx};
      s3_in.lng.den = s2_ff.lng.dy;
      s3_in.lng.quo = '0;
      s3_in.sht.neg = s2_ff.sht.neg;
      s3_in.sht.x0  = s2_ff.sht.x0;
      s3_in.sht.rem = {{COORD_BITS{1'b0}}, s2_ff.sht.dr} * {{COORD_BITS{1'b0}}, s2_ff.sht.adx};
      s3_in.sht.den = s2_ff.sht.dy;
      s3_in.sht.quo = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (adv0) begin
            s0_valid_ff <= req_valid;
         end
         if (adv1) begin
            s1_valid_ff <= s0_valid_ff;
         end
         if (adv2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (adv3) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv0) begin
         s0_ff <= req_data;
      end
      if (adv1) begin
         s1_ff <= s1_in;
      end
      if (adv2) begin
         s2_ff <= s2_in;
      end
      if (adv3) begin
         s3_ff <= s3_in;
      end
   end

   tss_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_ready  (div_in_ready),
      .in_data   (s3_ff),
      .out_valid (div_out_valid),
      .out_ready (adv_out),
      .out_data  (div_out_data)
   );

   // Apply the sign, add the edge origin and order the two x values.
   // Magnitude division followed by negation truncates toward zero.
   always_comb begin
      logic signed [COORD_BITS:0] ql, qs, xl_w, xs_w;
      coord_type xl, xs;
      ql   = div_out_data.lng.neg ? -$signed({1'b0, div_out_data.lng.quo})
                                  :  $signed({1'b0, div_out_data.lng.quo});
      qs   = div_out_data.sht.neg ? -$signed({1'b0, div_out_data.sht.quo})
                                  :  $signed({1'b0, div_out_data.sht.quo});
      xl_w = {div_out_data.lng.x0[COORD_BITS-1], div_out_data.lng.x0} + ql;
      xs_w = {div_out_data.sht.x0[COORD_BITS-1], div_out_data.sht.x0} + qs;
      xl   = coord_type'(xl_w[COORD_BITS-1:0]);
      xs   = coord_type'(xs_w[COORD_BITS-1:0]);

      rsp_in.span_valid = div_out_data.side.span_ok;
      rsp_in.span_row   = div_out_data.side.row;
      rsp_in.span_rgb   = div_out_data.side.rgb;
      rsp_in.span_alpha = div_out_data.side.alpha;
      if (!div_out_data.side.span_ok) begin
         rsp_in.span_left  = '0;
         rsp_in.span_right = '0;
      end else if (xl < xs) begin
         rsp_in.span_left  = xl;
         rsp_in.span_right = xs;
      end else begin
         rsp_in.span_left  = xs;
         rsp_in.span_right = xl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv_out) begin
         rsp_valid_ff <= div_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   // An invalid span always reports zero bounds.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.span_valid |-> rsp_data.span_left == '0
                                            && rsp_data.span_right == '0)
      else $error("invalid span with nonzero bounds");

   // A valid span is ordered.
   a_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.span_valid |-> rsp_data.span_left <= rsp_data.span_right)
      else $error("span left exceeds right");

   // Input backpressure only arises from a stalled output.
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req_ready low without output stall");
`endif

endmodule
